[sv/pcmp_pkg.sv]
// Package: shared types and constants of the PNG chunk metadata parser.
package pcmp_pkg;

   localparam int KEYWORD_LEN_DEF = 22;
   localparam int FIFO_DEPTH = 4;

   localparam logic [31:0] TAG_IHDR = 32'h49484452;
   localparam logic [31:0] TAG_ITXT = 32'h69545874;
   localparam logic [31:0] TAG_ICCP = 32'h69434350;
   localparam logic [31:0] TAG_SRGB = 32'h73524742;
   localparam logic [31:0] TAG_CHRM = 32'h6348524D;
   localparam logic [31:0] TAG_GAMA = 32'h67414D41;
   localparam logic [31:0] TAG_IEND = 32'h49454E44;
   localparam logic [31:0] LEN_MAX = 32'h7FFFFFFF;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;

   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_XMP  = 3'd1;
   localparam logic [2:0] KIND_ICCP = 3'd2;
   localparam logic [2:0] KIND_SRGB = 3'd3;
   localparam logic [2:0] KIND_CHRM = 3'd4;
   localparam logic [2:0] KIND_GAMA = 3'd5;

   localparam logic [1:0] STAT_NONE = 2'd0;
   localparam logic [1:0] STAT_OK   = 2'd1;
   localparam logic [1:0] STAT_KEY  = 2'd2;
   localparam logic [1:0] STAT_CRC  = 2'd3;

   localparam logic [2:0] STOP_RUN  = 3'd0;
   localparam logic [2:0] STOP_MAGIC = 3'd1;
   localparam logic [2:0] STOP_NOHDR = 3'd2;
   localparam logic [2:0] STOP_LEN  = 3'd3;
   localparam logic [2:0] STOP_CRC  = 3'd4;
   localparam logic [2:0] STOP_IEND = 3'd5;

   typedef enum logic [6:0] {
      PH_SIG  = 7'b0000001,
      PH_LEN  = 7'b0000010,
      PH_NAME = 7'b0000100,
      PH_SKIP = 7'b0001000,
      PH_CRC  = 7'b0010000,
      PH_DATA = 7'b0100000,
      PH_DONE = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic [2:0] chunk_kind;
      logic [1:0] chunk_status;
      logic       parse_done;
      logic [2:0] stop_reason;
   } result_type;

   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0: r = 8'h89;
         3'd1: r = 8'h50;
         3'd2: r = 8'h4E;
         3'd3: r = 8'h47;
         3'd4: r = 8'h0D;
         3'd5: r = 8'h0A;
         3'd6: r = 8'h1A;
         3'd7: r = 8'h0A;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xmp_byte(input logic [4:0] idx);
      logic [7:0] r;
      case (idx)
         5'd0: r = "X";
         5'd1: r = "M";
         5'd2: r = "L";
         5'd3: r = ":";
         5'd4: r = "c";
         5'd5: r = "o";
         5'd6: r = "m";
         5'd7: r = ".";
         5'd8: r = "a";
         5'd9: r = "d";
         5'd10: r = "o";
         5'd11: r = "b";
         5'd12: r = "e";
         5'd13: r = ".";
         5'd14: r = "x";
         5'd15: r = "m";
         5'd16: r = "p";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[sv/pcmp_front.sv]
// Front end: accepts bytes, walks the chunk structure and forms one result per byte.
module pcmp_front #(
   parameter int KEYWORD_LEN = pcmp_pkg::KEYWORD_LEN_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [7:0]           in_byte,
   input  logic                 advance,
   output pcmp_pkg::result_type res
);

   localparam logic [31:0] ITXT_MIN = 32'(KEYWORD_LEN + 54);

   pcmp_pkg::phase_type phase_ff, phase_in;
   logic [4:0]  step_ff, step_in;
   logic [31:0] len_ff, len_in, left_ff, left_in, tag_ff, tag_in;
   logic [31:0] crc_ff, crc_in, scrc_ff, scrc_in;
   logic        hdr_ff, hdr_in, key_ff, key_in;
   logic [4:0]  caps_ff, caps_in;
   logic [2:0]  kind_ff, kind_in, stop_ff, stop_in;

   logic [31:0] tag_nx, len_nx, scrc_nx, offset;
   logic [2:0]  ck;

   always_comb begin
      phase_in = phase_ff; step_in = step_ff; len_in = len_ff; left_in = left_ff;
      tag_in = tag_ff; crc_in = crc_ff; scrc_in = scrc_ff; hdr_in = hdr_ff;
      key_in = key_ff; caps_in = caps_ff; kind_in = kind_ff; stop_in = stop_ff;
      res = '0;
      res.out_byte = in_byte;
      tag_nx = {tag_ff[23:0], in_byte};
      len_nx = (step_ff == 5'd0) ? {24'd0, in_byte} : {len_ff[23:0], in_byte};
      scrc_nx = (step_ff == 5'd0) ? {24'd0, in_byte} : {scrc_ff[23:0], in_byte};
      offset = len_ff - left_ff;
      ck = pcmp_pkg::KIND_NONE;
      case (phase_ff)
         pcmp_pkg::PH_SIG: begin
            if (in_byte == pcmp_pkg::sig_byte(step_ff[2:0])) begin
               step_in = step_ff + 5'd1;
               if (step_ff == 5'd7) begin
                  step_in = '0;
                  phase_in = pcmp_pkg::PH_LEN;
               end
            end else begin
               phase_in = pcmp_pkg::PH_DONE;
               stop_in = pcmp_pkg::STOP_MAGIC;
            end
         end
         pcmp_pkg::PH_LEN: begin
            len_in = len_nx;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd3) begin
               step_in = '0;
               if (len_nx > pcmp_pkg::LEN_MAX) begin
                  phase_in = pcmp_pkg::PH_DONE;
                  stop_in = pcmp_pkg::STOP_LEN;
               end else begin
                  crc_in = '1;
                  phase_in = pcmp_pkg::PH_NAME;
               end
            end
         end
         pcmp_pkg::PH_NAME: begin
            tag_in = tag_nx;
            crc_in = pcmp_pkg::crc_byte(crc_ff, in_byte);
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd3) begin
               step_in = '0;
               if (!hdr_ff && !(len_ff == 32'd13 && tag_nx == pcmp_pkg::TAG_IHDR)) begin
                  phase_in = pcmp_pkg::PH_DONE;
                  stop_in = pcmp_pkg::STOP_NOHDR;
               end else begin
                  hdr_in = 1'b1;
                  if (tag_nx == pcmp_pkg::TAG_ITXT && len_ff > ITXT_MIN && !caps_ff[0])
                     ck = pcmp_pkg::KIND_XMP;
                  else if (tag_nx == pcmp_pkg::TAG_ICCP && !caps_ff[1])
                     ck = pcmp_pkg::KIND_ICCP;
                  else if (tag_nx == pcmp_pkg::TAG_SRGB && !caps_ff[2] && len_ff == 32'd1)
                     ck = pcmp_pkg::KIND_SRGB;
                  else if (tag_nx == pcmp_pkg::TAG_CHRM && !caps_ff[3] && len_ff == 32'd32)
                     ck = pcmp_pkg::KIND_CHRM;
                  else if (tag_nx == pcmp_pkg::TAG_GAMA && !caps_ff[4] && len_ff == 32'd4)
                     ck = pcmp_pkg::KIND_GAMA;
                  if (ck != pcmp_pkg::KIND_NONE) begin
                     caps_in = caps_ff | (5'd1 << (ck - 3'd1));
                     kind_in = ck;
                     key_in = 1'b1;
                     left_in = len_ff;
                     phase_in = (len_ff == 32'd0) ? pcmp_pkg::PH_CRC : pcmp_pkg::PH_DATA;
                  end else if (tag_nx == pcmp_pkg::TAG_IEND) begin
                     phase_in = pcmp_pkg::PH_DONE;
                     stop_in = pcmp_pkg::STOP_IEND;
                  end else begin
                     left_in = len_ff + 32'd4;
                     phase_in = pcmp_pkg::PH_SKIP;
                  end
               end
            end
         end
         pcmp_pkg::PH_SKIP: begin
            if (left_ff <= 32'd1) begin
               left_in = '0;
               step_in = '0;
               phase_in = pcmp_pkg::PH_LEN;
            end else begin
               left_in = left_ff - 32'd1;
            end
         end
         pcmp_pkg::PH_DATA: begin
            if (kind_ff == pcmp_pkg::KIND_XMP && offset < 32'(KEYWORD_LEN)
                && in_byte != pcmp_pkg::xmp_byte(offset[4:0]))
               key_in = 1'b0;
            crc_in = pcmp_pkg::crc_byte(crc_ff, in_byte);
            res.out_valid = 1'b1;
            res.chunk_kind = kind_ff;
            if (left_ff <= 32'd1) begin
               left_in = '0;
               step_in = '0;
               if (kind_ff == pcmp_pkg::KIND_XMP && !key_in) begin
                  res.chunk_status = pcmp_pkg::STAT_KEY;
                  caps_in = caps_ff & ~5'd1;
                  left_in = 32'd4;
                  phase_in = pcmp_pkg::PH_SKIP;
               end else begin
                  phase_in = pcmp_pkg::PH_CRC;
               end
            end else begin
               left_in = left_ff - 32'd1;
            end
         end
         pcmp_pkg::PH_CRC: begin
            scrc_in = scrc_nx;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd3) begin
               step_in = '0;
               res.chunk_kind = kind_ff;
               if (~crc_ff == scrc_nx) begin
                  res.chunk_status = pcmp_pkg::STAT_OK;
                  phase_in = pcmp_pkg::PH_LEN;
               end else begin
                  res.chunk_status = pcmp_pkg::STAT_CRC;
                  phase_in = pcmp_pkg::PH_DONE;
                  stop_in = pcmp_pkg::STOP_CRC;
               end
            end
         end
         default: phase_in = pcmp_pkg::PH_DONE;
      endcase
      res.parse_done = (phase_in == pcmp_pkg::PH_DONE);
      res.stop_reason = stop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pcmp_pkg::PH_SIG; step_ff <= '0; len_ff <= '0; left_ff <= '0;
         tag_ff <= '0; crc_ff <= '1; scrc_ff <= '0; hdr_ff <= 1'b0; key_ff <= 1'b1;
         caps_ff <= '0; kind_ff <= '0; stop_ff <= '0;
      end else if (in_valid && advance) begin
         phase_ff <= phase_in; step_ff <= step_in; len_ff <= len_in; left_ff <= left_in;
         tag_ff <= tag_in; crc_ff <= crc_in; scrc_ff <= scrc_in; hdr_ff <= hdr_in;
         key_ff <= key_in; caps_ff <= caps_in; kind_ff <= kind_in; stop_ff <= stop_in;
      end
   end

endmodule

[sv/pcmp_queue.sv]
// Back end: short result queue between the parser and the result channel.
module pcmp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pcmp_pkg::result_type push_data,
   output logic                 full,
   output logic                 pop_valid,
   input  logic                 pop,
   output pcmp_pkg::result_type pop_data
);

   localparam int AW = $clog2(pcmp_pkg::FIFO_DEPTH);

   pcmp_pkg::result_type mem_ff [pcmp_pkg::FIFO_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;

   assign full = (cnt_ff == (AW+1)'(pcmp_pkg::FIFO_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

endmodule

[sv/png_chunk_metadata_parser_top.sv]
// Top level of the PNG chunk metadata parser.
//  channel | direction | ports
//  req     | in        | req_valid, req_stall, req_data_byte
//  rsp     | out       | rsp_valid, rsp_stall, rsp_out_byte .. rsp_stop_reason
// One byte per cycle while req_stall is low; each byte yields one result that is
// registered in a four-entry result queue, whose fill level sets req_stall.
// Reset clears parser state and empties the queue.
// rsp_stall holds results in the queue; input keeps flowing until it fills.
module png_chunk_metadata_parser_top #(
   parameter int KEYWORD_LEN = pcmp_pkg::KEYWORD_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic [2:0] rsp_chunk_kind,
   output logic [1:0] rsp_chunk_status,
   output logic       rsp_parse_done,
   output logic [2:0] rsp_stop_reason
);

   pcmp_pkg::result_type res, qout;
   logic full, take;

   assign req_stall = full;
   assign take = req_valid && !full;

   pcmp_front #(.KEYWORD_LEN(KEYWORD_LEN)) u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_byte(req_data_byte),
      .advance(!full), .res(res)
   );

   pcmp_queue u_queue (
      .clock(clock), .reset(reset), .push(take), .push_data(res), .full(full),
      .pop_valid(rsp_valid), .pop(rsp_valid && !rsp_stall), .pop_data(qout)
   );

   assign rsp_out_byte = qout.out_byte;
   assign rsp_out_valid = qout.out_valid;
   assign rsp_chunk_kind = qout.chunk_kind;
   assign rsp_chunk_status = qout.chunk_status;
   assign rsp_parse_done = qout.parse_done;
   assign rsp_stop_reason = qout.stop_reason;

endmodule
